### hdl/lru_key_value_cache_defines.svh
// assertion macros for the lru key value cache checker
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LKVC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lkvc same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lkvc next-cycle check failed");

`endif

### hdl/lkvc_pkg.sv
// shared types and constants of the lru key value cache
`default_nettype none

package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;
	localparam logic [VAL_W-1:0]     MISS_VALUE   = 32'hFFFF_FFFF;
	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} request_t;

endpackage

`default_nettype wire

### hdl/lru_key_value_cache.sv
// lru key value cache: fully associative table with least recently used replacement
//
// requests enter on start while busy is low; operation picks get or put, lookup_key
// and write_value carry the word. busy stays low, so a request may enter every cycle.
// the request is registered, then combinational logic compares the key against all
// entries in parallel, updates the per-entry recency ranks and valid marks, and
// registers the result. done pulses for one cycle, after the request register and
// the result register, with hit, read_value, evicted and evicted_key; throughput is
// one request per cycle, set by the single compare-and-rank stage over all entries.
// a get miss and every put return read_value of all ones; evicted_key is zero
// unless evicted is set. a put of a new key with the table at capacity evicts the
// least recent entry first.
// capacity_in_use is written over the apb port at byte address 0 (0 acts as 1,
// values above the entry count act as the entry count). write it only while idle.
// reset empties the table at once (valid marks and fill count cleared) and sets the
// capacity to 16. results cannot be held off: the receiver must take done as it comes.
`default_nettype none

module lru_key_value_cache (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              operation,
	input  wire logic [lkvc_pkg::KEY_W-1:0]        lookup_key,
	input  wire logic signed [lkvc_pkg::VAL_W-1:0] write_value,
	output logic                                   done,
	output logic                                   hit,
	output logic signed [lkvc_pkg::VAL_W-1:0]      read_value,
	output logic                                   evicted,
	output logic [lkvc_pkg::KEY_W-1:0]             evicted_key,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lkvc_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [lkvc_pkg::DATA_W-1:0]       pwdata,
	output logic [lkvc_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready
);

	localparam int N = lkvc_pkg::ENTRIES;

	logic [lkvc_pkg::CAP_W-1:0]  cap_q;
	logic [lkvc_pkg::CNT_W-1:0]  eff_cap;
	logic                        reg_sel;

	lkvc_pkg::request_t          req_s1;
	logic                        vld_s1;

	logic [lkvc_pkg::KEY_W-1:0]  key_q  [N];
	logic [lkvc_pkg::VAL_W-1:0]  val_q  [N];
	logic [lkvc_pkg::RANK_W-1:0] rank_q [N];
	logic [lkvc_pkg::RANK_W-1:0] rank_d [N];
	logic [lkvc_pkg::RANK_W-1:0] rank_touch [N];
	logic [N-1:0]                valid_q;
	logic [N-1:0]                valid_d;
	logic [lkvc_pkg::CNT_W-1:0]  used_q;
	logic [lkvc_pkg::CNT_W-1:0]  used_d;

	logic [N-1:0]                hit_vec;
	logic                        hit_any;
	logic [lkvc_pkg::IDX_W-1:0]  hit_idx;
	logic [lkvc_pkg::RANK_W-1:0] hit_rank;
	logic [lkvc_pkg::RANK_W-1:0] last_rank;
	logic [N-1:0]                old_pre;
	logic [N-1:0]                old_post;
	logic [N-1:0]                old_sel;
	logic                        old_any;
	logic [lkvc_pkg::IDX_W-1:0]  old_idx;
	logic [N-1:0]                free_vec;
	logic                        free_any;
	logic [lkvc_pkg::IDX_W-1:0]  free_idx;
	logic                        put_hit;
	logic                        ev_d;

	logic                        key_we;
	logic                        val_we;
	logic [lkvc_pkg::IDX_W-1:0]  wr_idx;

	logic                        hit_d;
	logic [lkvc_pkg::VAL_W-1:0]  rd_d;
	logic [lkvc_pkg::KEY_W-1:0]  evk_d;

	logic                        done_s2;
	logic                        hit_s2;
	logic [lkvc_pkg::VAL_W-1:0]  rd_s2;
	logic                        ev_s2;
	logic [lkvc_pkg::KEY_W-1:0]  evk_s2;

	// configuration port
	assign reg_sel = (paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? lkvc_pkg::DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[lkvc_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkvc_pkg::CNT_W'(1);
		end else if (32'(cap_q) > 32'(N)) begin
			eff_cap = lkvc_pkg::CNT_W'(N);
		end else begin
			eff_cap = lkvc_pkg::CNT_W'(cap_q);
		end
	end

	// request register
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1.op    <= lkvc_pkg::op_t'(operation);
			req_s1.key   <= lookup_key;
			req_s1.value <= write_value;
		end
	end

	// key match and recency
	assign last_rank = lkvc_pkg::RANK_W'(used_q - lkvc_pkg::CNT_W'(1));

	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit_vec[i] = valid_q[i] && (key_q[i] == req_s1.key);
		end
		hit_any = |hit_vec;
		hit_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = lkvc_pkg::IDX_W'(i);
			end
		end
	end

	assign hit_rank = rank_q[hit_idx];
	assign put_hit  = (req_s1.op == lkvc_pkg::OP_PUT) && hit_any;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (lkvc_pkg::IDX_W'(i) == hit_idx) begin
				rank_touch[i] = '0;
			end else if (rank_q[i] < hit_rank) begin
				rank_touch[i] = rank_q[i] + lkvc_pkg::RANK_W'(1);
			end else begin
				rank_touch[i] = rank_q[i];
			end
			old_pre[i]  = valid_q[i] && (rank_q[i] == last_rank);
			old_post[i] = valid_q[i] && (rank_touch[i] == last_rank);
		end
	end

	// oldest entry, taken after the touch on a put hit
	always_comb begin
		old_sel = put_hit ? old_post : old_pre;
		old_any = |old_sel;
		old_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (old_sel[i]) begin
				old_idx = lkvc_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		ev_d = 1'b0;
		if (vld_s1 && req_s1.op == lkvc_pkg::OP_PUT) begin
			if (hit_any) begin
				ev_d = (used_q > eff_cap) && old_any;
			end else begin
				ev_d = (used_q >= eff_cap) && old_any;
			end
		end
	end

	// first free slot once the evicted entry is gone
	always_comb begin
		free_vec = ~valid_q;
		if (ev_d) begin
			free_vec[old_idx] = 1'b1;
		end
		free_any = |free_vec;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = lkvc_pkg::IDX_W'(i);
			end
		end
	end

	// next state and result
	always_comb begin
		rank_d  = rank_q;
		valid_d = valid_q;
		used_d  = used_q;
		key_we  = 1'b0;
		val_we  = 1'b0;
		wr_idx  = hit_idx;
		hit_d   = 1'b0;
		rd_d    = lkvc_pkg::MISS_VALUE;
		evk_d   = ev_d ? key_q[old_idx] : '0;
		if (vld_s1) begin
			case (req_s1.op)
				lkvc_pkg::OP_GET: begin
					if (hit_any) begin
						hit_d  = 1'b1;
						rd_d   = val_q[hit_idx];
						rank_d = rank_touch;
					end
				end
				lkvc_pkg::OP_PUT: begin
					if (hit_any) begin
						hit_d  = 1'b1;
						val_we = 1'b1;
						rank_d = rank_touch;
						if (ev_d) begin
							valid_d[old_idx] = 1'b0;
							rank_d[old_idx]  = '0;
							used_d           = used_q - lkvc_pkg::CNT_W'(1);
						end
					end else begin
						if (ev_d) begin
							valid_d[old_idx] = 1'b0;
							rank_d[old_idx]  = '0;
						end
						if (free_any) begin
							for (int i = 0; i < N; i++) begin
								if (valid_d[i]) begin
									rank_d[i] = rank_d[i] + lkvc_pkg::RANK_W'(1);
								end
							end
							wr_idx            = free_idx;
							key_we            = 1'b1;
							val_we            = 1'b1;
							valid_d[free_idx] = 1'b1;
							rank_d[free_idx]  = '0;
							used_d = ev_d ? used_q : used_q + lkvc_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
					hit_d = 1'b0;
				end
			endcase
		end
	end

	// table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			used_q  <= used_d;
			rank_q  <= rank_d;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q[wr_idx] <= req_s1.key;
		end
		if (val_we) begin
			val_q[wr_idx] <= req_s1.value;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_s2 <= hit_d;
			rd_s2  <= rd_d;
			ev_s2  <= ev_d;
			evk_s2 <= evk_d;
		end
	end

	assign done        = done_s2;
	assign hit         = hit_s2;
	assign read_value  = rd_s2;
	assign evicted     = ev_s2;
	assign evicted_key = evk_s2;

endmodule

`default_nettype wire

### hdl/lkvc_chk.sv
// port checker for the lru key value cache, bound to the top level
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lkvc_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              operation,
	input wire logic                              done,
	input wire logic                              hit,
	input wire logic signed [lkvc_pkg::VAL_W-1:0] read_value,
	input wire logic                              evicted,
	input wire logic [lkvc_pkg::KEY_W-1:0]        evicted_key
);

	// every accepted word gives exactly one result, after the request and result registers
	`LKVC_ASSERT_NEXT(a_accept_gives_done, start && !busy, ##0 1'b1 ##1 done)
	`LKVC_ASSERT_NEXT(a_idle_no_done, !(start && !busy), ##1 !done)

	// a get never evicts
	`LKVC_ASSERT_NEXT(a_get_no_evict, start && !busy && !operation, ##1 !evicted)

	// result field coding
	`LKVC_ASSERT_SAME(a_miss_value, done && !hit, read_value == lkvc_pkg::MISS_VALUE)
	`LKVC_ASSERT_SAME(a_no_evict_key_zero, done && !evicted, evicted_key == '0)

endmodule

bind lru_key_value_cache lkvc_chk u_lkvc_chk (.*);

`default_nettype wire

### tb/sv/lru_key_value_cache_test.sv
// self-checking testbench for the lru key value cache: directed and random get/put traffic
`timescale 1ns / 100ps
`default_nettype none

module lru_key_value_cache_test;

	import lkvc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_WORDS = 110;

	typedef struct {
		bit                      hit;
		logic signed [VAL_W-1:0] read_value;
		bit                      evicted;
		logic [KEY_W-1:0]        evicted_key;
	} reply_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      operation;
	logic [KEY_W-1:0]          lookup_key;
	logic signed [VAL_W-1:0]   write_value;
	logic                      done;
	logic                      hit;
	logic signed [VAL_W-1:0]   read_value;
	logic                      evicted;
	logic [KEY_W-1:0]          evicted_key;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ADDR_W-1:0]         paddr;
	logic [DATA_W-1:0]         pwdata;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	// behavioral copy of the table
	logic [KEY_W-1:0] slot_key [ENTRIES];
	logic [VAL_W-1:0] slot_value [ENTRIES];
	bit               slot_used [ENTRIES];
	int               slot_age [ENTRIES];
	int               fill_count;
	logic [CAP_W-1:0] capacity_reg;

	reply_t           pending_replies [$];
	int               mismatch_count;
	int               cycle_count;
	bit               gaps_enabled;
	logic [KEY_W-1:0] key_pool [24];

	lru_key_value_cache uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.lookup_key(lookup_key),
		.write_value(write_value),
		.done(done),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.evicted_key(evicted_key),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[lru_key_value_cache] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	// make slot s most recent; younger entries age by one
	function automatic void promote(int s);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && i != s && slot_age[i] < slot_age[s])
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	function automatic void evict_oldest(inout reply_t r);
		int s;
		s = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && (s < 0 || slot_age[i] > slot_age[s]))
				s = i;
		if (s >= 0) begin
			r.evicted = 1'b1;
			r.evicted_key = slot_key[s];
			slot_used[s] = 1'b0;
			slot_age[s] = 0;
			if (fill_count > 0)
				fill_count--;
		end
	endfunction

	function automatic reply_t cache_lookup(op_t op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value);
		reply_t r;
		int cap;
		int s;
		int f;
		r.hit = 1'b0;
		r.read_value = MISS_VALUE;
		r.evicted = 1'b0;
		r.evicted_key = '0;
		cap = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
		s = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (s < 0 && slot_used[i] && slot_key[i] == key)
				s = i;
		if (op == OP_GET) begin
			if (s >= 0) begin
				r.hit = 1'b1;
				r.read_value = slot_value[s];
				promote(s);
			end
		end else if (s >= 0) begin
			r.hit = 1'b1;
			slot_value[s] = value;
			promote(s);
			if (fill_count > cap)
				evict_oldest(r);
		end else begin
			if (fill_count >= cap)
				evict_oldest(r);
			f = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (f < 0 && !slot_used[i])
					f = i;
			if (f >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i])
						slot_age[i]++;
				slot_key[f] = key;
				slot_value[f] = value;
				slot_used[f] = 1'b1;
				slot_age[f] = 0;
				fill_count++;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected word", 32'd0, 32'd1);
			end else begin
				want = pending_replies.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", 32'(want.hit), 32'(hit));
				if (read_value !== want.read_value)
					report_mismatch("read_value", want.read_value, read_value);
				if (evicted !== want.evicted)
					report_mismatch("evicted", 32'(want.evicted), 32'(evicted));
				if (evicted_key !== want.evicted_key)
					report_mismatch("evicted_key", want.evicted_key, evicted_key);
			end
		end
	end

	task automatic send_word(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		int gap;
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			@(negedge clk);
			start = 1'b0;
			operation = 1'($urandom_range(0, 1));
			lookup_key = $urandom;
			write_value = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		operation = op;
		lookup_key = key;
		write_value = value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_replies.push_back(cache_lookup(op, key, value));
	endtask

	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_CAPACITY, 2'b00};
		pwdata = DATA_W'(cap);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		capacity_reg = cap;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== DATA_W'(cap))
			report_mismatch("prdata", DATA_W'(cap), prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic test_basic_get_put;
		send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_word(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
		send_word(OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
		send_word(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_word(OP_GET, 32'h0000_0005, 32'h0000_0000);
	endtask

	task automatic test_eviction_order;
		drain();
		write_capacity(5'd2);
		send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(OP_PUT, 32'h1234_5678, 32'h0000_0001);
		send_word(OP_PUT, 32'hA5A5_A5A5, 32'h0000_0002);
	endtask

	// capacity zero acts as one, and lowering it leaves extra entries in place
	task automatic test_capacity_shrink;
		drain();
		write_capacity(5'd0);
		send_word(OP_PUT, 32'h0000_0001, 32'h5555_5555);
		send_word(OP_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
		send_word(OP_GET, 32'hA5A5_A5A5, 32'h0000_0000);
		send_word(OP_GET, 32'h0000_0001, 32'h0000_0000);
		drain();
		write_capacity(5'd31);
		send_word(OP_PUT, 32'h0000_0002, 32'h0000_0003);
		send_word(OP_PUT, 32'h0000_0003, 32'h0000_0004);
		send_word(OP_GET, 32'h0000_0001, 32'h0000_0000);
	endtask

	task automatic test_random_traffic(logic [CAP_W-1:0] cap, int count, bit with_gaps);
		int pool_n;
		logic [KEY_W-1:0] key;
		drain();
		write_capacity(cap);
		gaps_enabled = with_gaps;
		pool_n = ((cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap)) + 3;
		repeat (4)
			key_pool[$urandom_range(0, 23)] = $urandom;
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(0, pool_n - 1)];
			send_word(op_t'($urandom_range(0, 1)), key, $urandom);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps [9];
		arst_n = 1'b0;
		start = 1'b0;
		operation = 1'b0;
		lookup_key = '0;
		write_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatch_count = 0;
		cycle_count = 0;
		gaps_enabled = 1'b1;
		fill_count = 0;
		capacity_reg = CAP_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_used[i] = 1'b0;
			slot_age[i] = 0;
		end
		for (int i = 0; i < 24; i++)
			key_pool[i] = $urandom;
		phase_caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16};
		phase_caps[6] = CAP_W'($urandom_range(0, 31));
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_basic_get_put();
		test_eviction_order();
		test_capacity_shrink();
		for (int p = 0; p < 9; p++)
			test_random_traffic(phase_caps[p], PHASE_WORDS, p < 8);

		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_replies.size() == 0)
			$display("[lru_key_value_cache] OK");
		else
			$display("[lru_key_value_cache] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
